@@ hw/rtl/timed_exclusion_table_core_macros.svh @@
// assertion macros for the timed exclusion table checker
`ifndef TIMED_EXCLUSION_TABLE_CORE_MACROS_SVH
`define TIMED_EXCLUSION_TABLE_CORE_MACROS_SVH

// check that holds outside reset
`define TET_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("timed exclusion table check failed");

// check that also holds while reset is applied
`define TET_ASSERT_IN_RESET(label, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("timed exclusion table reset check failed");

`endif

@@ hw/rtl/tet_pkg.sv @@
// shared types and constants for the timed exclusion table
package tet_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
    localparam int KEY_W         = 16;
    localparam int TIME_W        = 32;
    localparam int DUR_W         = 16;
    localparam int SLOT_W        = 4;

    localparam logic KIND_QUERY = 1'b0;
    localparam logic KIND_ADD   = 1'b1;

    typedef enum logic [1:0] {
        ACT_NONE    = 2'd0,
        ACT_REFRESH = 2'd1,
        ACT_APPEND  = 2'd2,
        ACT_REPLACE = 2'd3
    } tet_action_t;

    typedef struct packed {
        logic                     kind;
        logic signed [KEY_W-1:0]  key;
        logic        [TIME_W-1:0] now;
        logic        [DUR_W-1:0]  duration;
    } tet_req_t;

    typedef struct packed {
        logic              blocked;
        tet_action_t       action;
        logic [SLOT_W-1:0] slot;
    } tet_rsp_t;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [TIME_W-1:0] expiry;
    } tet_entry_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic read;
        logic check;
        logic inc;
        logic finish;
    } tet_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic skip;
        logic hit_now;
        logic last;
        logic out_busy;
    } tet_stat_t;

    // low slot bits of an entry index
    function automatic logic [SLOT_W-1:0] to_slot(input logic [IDX_W-1:0] idx);
        logic [IDX_W+SLOT_W-1:0] wide;
        wide = {{SLOT_W{1'b0}}, idx};
        return wide[SLOT_W-1:0];
    endfunction

    // now + duration, saturated at the top of the time range
    function automatic logic [TIME_W-1:0] sat_expiry(input logic [TIME_W-1:0] now,
                                                     input logic [DUR_W-1:0]  dur);
        logic [TIME_W:0] sum;
        sum = {1'b0, now} + {{(TIME_W + 1 - DUR_W){1'b0}}, dur};
        return sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
    endfunction

endpackage

@@ hw/rtl/tet_ram.sv @@
// generic single-port-write, single-port-read ram with registered read
module tet_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hw/rtl/tet_datapath.sv @@
// request register, entry scan, match and minimum tracking, result register
module tet_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  tet_pkg::tet_cmd_t cmd,
    output tet_pkg::tet_stat_t stat,
    input  tet_pkg::tet_req_t req,
    output tet_pkg::tet_rsp_t rsp,
    output logic              rsp_valid,
    input  logic              rsp_ready
);

    logic                             kind_reg;
    logic [tet_pkg::KEY_W-1:0]        key_reg;
    logic [tet_pkg::TIME_W-1:0]       now_reg;
    logic [tet_pkg::TIME_W-1:0]       exp_reg;
    logic [tet_pkg::IDX_W-1:0]        idx_reg;
    logic [tet_pkg::CNT_W-1:0]        fill_reg;
    logic [tet_pkg::CNT_W-1:0]        fill_next;
    logic                             hit_reg;
    logic [tet_pkg::IDX_W-1:0]        hit_idx_reg;
    logic [tet_pkg::TIME_W-1:0]       min_reg;
    logic [tet_pkg::IDX_W-1:0]        min_idx_reg;
    tet_pkg::tet_rsp_t                rsp_reg;
    tet_pkg::tet_rsp_t                rsp_next;
    logic                             rsp_valid_reg;

    tet_pkg::tet_entry_t              rd_entry;
    tet_pkg::tet_entry_t              wr_entry;
    logic                             wr_en;
    logic [tet_pkg::IDX_W-1:0]        wr_idx;
    logic                             negative;
    logic                             full;
    logic                             hit_now;
    logic                             new_min;

    tet_ram #(
        .WIDTH($bits(tet_pkg::tet_entry_t)),
        .DEPTH(tet_pkg::TABLE_ENTRIES)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_idx),
        .wr_data (wr_entry),
        .rd_en   (cmd.read),
        .rd_addr (idx_reg),
        .rd_data (rd_entry)
    );

    assign negative = key_reg[tet_pkg::KEY_W-1];
    assign full     = (fill_reg == tet_pkg::CNT_W'(tet_pkg::TABLE_ENTRIES));

    // query needs a live expiry, add only the key
    assign hit_now = cmd.check && (rd_entry.key == key_reg)
                     && ((kind_reg == tet_pkg::KIND_ADD) || (rd_entry.expiry > now_reg));
    assign new_min = (idx_reg == '0) || (rd_entry.expiry < min_reg);

    assign stat.skip     = negative || (fill_reg == '0);
    assign stat.hit_now  = hit_now;
    assign stat.last     = ((tet_pkg::CNT_W'(idx_reg) + tet_pkg::CNT_W'(1)) == fill_reg);
    assign stat.out_busy = rsp_valid_reg && !rsp_ready;

    always_comb
    begin
        rsp_next  = '{blocked: 1'b0, action: tet_pkg::ACT_NONE, slot: '0};
        wr_en     = 1'b0;
        wr_idx    = idx_reg;
        fill_next = fill_reg;
        wr_entry  = '{key: key_reg, expiry: exp_reg};
        if (!negative)
        begin
            if (kind_reg == tet_pkg::KIND_QUERY)
            begin
                rsp_next.blocked = hit_reg;
            end
            else
            begin
                wr_en = cmd.finish;
                priority if (hit_reg)
                begin
                    rsp_next.action = tet_pkg::ACT_REFRESH;
                    wr_idx          = hit_idx_reg;
                end
                else if (!full)
                begin
                    rsp_next.action = tet_pkg::ACT_APPEND;
                    wr_idx          = fill_reg[tet_pkg::IDX_W-1:0];
                    fill_next       = fill_reg + tet_pkg::CNT_W'(1);
                end
                else
                begin
                    rsp_next.action = tet_pkg::ACT_REPLACE;
                    wr_idx          = min_idx_reg;
                end
                rsp_next.slot = tet_pkg::to_slot(wr_idx);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            hit_reg       <= 1'b0;
            rsp_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                hit_reg <= 1'b0;
                idx_reg <= '0;
            end
            else if (cmd.inc)
            begin
                idx_reg <= idx_reg + tet_pkg::IDX_W'(1);
            end
            if (hit_now)
            begin
                hit_reg <= 1'b1;
            end
            if (cmd.finish)
            begin
                fill_reg      <= fill_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg <= req.kind;
            key_reg  <= req.key;
            now_reg  <= req.now;
            exp_reg  <= tet_pkg::sat_expiry(req.now, req.duration);
        end
        if (hit_now)
        begin
            hit_idx_reg <= idx_reg;
        end
        if (cmd.check && new_min)
        begin
            min_reg     <= rd_entry.expiry;
            min_idx_reg <= idx_reg;
        end
        if (cmd.finish)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp       = rsp_reg;
    assign rsp_valid = rsp_valid_reg;

endmodule

@@ hw/rtl/tet_ctrl.sv @@
// sequencer for the entry scan
module tet_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  tet_pkg::tet_stat_t stat,
    output tet_pkg::tet_cmd_t  cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_DECIDE
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                if (stat.skip)
                begin
                    state_next = ST_DECIDE;
                end
                else
                begin
                    cmd.read   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                cmd.check = 1'b1;
                if (stat.hit_now || stat.last)
                begin
                    state_next = ST_DECIDE;
                end
                else
                begin
                    cmd.inc    = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_DECIDE:
            begin
                if (!stat.out_busy)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign req_ready = (state_reg == ST_IDLE);

endmodule

@@ hw/rtl/timed_exclusion_table_core.sv @@
// top level of the timed exclusion table: controller plus datapath
// scan: a negative key or an empty table skips the scan and goes straight to decide, else
// each filled entry is read and then checked, and the scan stops at a match
// flow: one request in flight; the sequencer is ready for the next transfer in the same
// cycle that the result goes valid, and decide waits while an earlier result is stalled
// reset: rst_n clears fill count, controller and result valid; entries undefined until written
module timed_exclusion_table_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  tet_pkg::tet_req_t req,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output tet_pkg::tet_rsp_t rsp
);

    // command and status between sequencer and datapath
    tet_pkg::tet_cmd_t  cmd;
    tet_pkg::tet_stat_t stat;

    // sequencer: idle, read/check loop over the filled entries, then decide
    // a waiting result does not block the next request, only the decide step
    tet_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // datapath: request capture, entry ram, match/min tracking, result register
    // a full table is scanned end to end on a miss, so the earliest expiry
    // is known from the same pass that looked for the key
    tet_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .req       (req),
        .rsp       (rsp),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready)
    );

endmodule

@@ hw/rtl/tet_checker.sv @@
// port-level checks for the timed exclusion table, bound to the top level
`include "timed_exclusion_table_core_macros.svh"

module tet_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              req_valid,
    input logic              req_ready,
    input tet_pkg::tet_req_t req,
    input logic              rsp_valid,
    input logic              rsp_ready,
    input tet_pkg::tet_rsp_t rsp
);

    // one request in flight: ready drops right after a transfer
    `TET_ASSERT(a_one_at_a_time, req_valid && req_ready |=> !req_ready)

    // an idle block stays ready until a request arrives
    `TET_ASSERT(a_idle_stays_ready, req_ready && !req_valid |=> req_ready)

    // a waiting request holds its payload
    `TET_ASSERT(a_req_hold, req_valid && !req_ready |=> req_valid && $stable(req))

    // a stalled result holds
    `TET_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))

    // no result shows while reset is applied
    `TET_ASSERT_IN_RESET(a_no_rsp_in_reset, !rst_n |-> !rsp_valid)

endmodule

bind timed_exclusion_table_core tet_checker u_tet_checker (.*);

@@ bench/timed_exclusion_table_checker.sv @@
// checker for the timed exclusion table: predicts each verdict and compares results
module timed_exclusion_table_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    input  logic              req_ready,
    input  tet_pkg::tet_req_t req,
    input  logic              rsp_valid,
    input  logic              rsp_ready,
    input  tet_pkg::tet_rsp_t rsp,
    output int                fail_count,
    output int                pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import tet_pkg::*;

    // own copy of the table
    logic [KEY_W-1:0]  held_key    [TABLE_ENTRIES];
    logic [TIME_W-1:0] held_expiry [TABLE_ENTRIES];
    int                held_count = 0;

    tet_rsp_t verdicts_due[$];
    int       mismatches = 0;
    int       due_count  = 0;

    assign fail_count = mismatches;
    assign pending    = due_count;

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("checker: %s mismatch at %0t, got %0h expected %0h", field, $realtime,
                 got, want);
        mismatches++;
    endtask

    // works out the verdict of one request and updates the table copy
    task automatic judge_request(input tet_req_t r, output tet_rsp_t v);
        logic [TIME_W:0]   sum;
        logic [TIME_W-1:0] expiry;
        int                best;
        bit                done;
        v = '0;
        v.action = ACT_NONE;
        done = 0;
        if (!r.key[KEY_W-1]) begin
            if (r.kind == KIND_QUERY) begin
                for (int i = 0; i < held_count; i++)
                    if (!done && held_key[i] == r.key && held_expiry[i] > r.now) begin
                        v.blocked = 1'b1;
                        done = 1;
                    end
            end else begin
                sum = {1'b0, r.now} + {{(TIME_W + 1 - DUR_W){1'b0}}, r.duration};
                expiry = sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
                for (int i = 0; i < held_count; i++)
                    if (!done && held_key[i] == r.key) begin
                        held_expiry[i] = expiry;
                        v.action = ACT_REFRESH;
                        v.slot = SLOT_W'(i);
                        done = 1;
                    end
                if (!done && held_count >= TABLE_ENTRIES) begin
                    // full: earliest expiry goes, lowest index on a tie
                    best = 0;
                    for (int i = 1; i < TABLE_ENTRIES; i++)
                        if (held_expiry[i] < held_expiry[best])
                            best = i;
                    held_key[best] = r.key;
                    held_expiry[best] = expiry;
                    v.action = ACT_REPLACE;
                    v.slot = SLOT_W'(best);
                end else if (!done) begin
                    held_key[held_count] = r.key;
                    held_expiry[held_count] = expiry;
                    v.action = ACT_APPEND;
                    v.slot = SLOT_W'(held_count);
                    held_count++;
                end
            end
        end
    endtask

    always @(posedge clk) begin
        tet_rsp_t want;
        if (rst_n) begin
            // results first: a result never belongs to a request taken at the same edge
            if (rsp_valid && rsp_ready) begin
                if (verdicts_due.size() == 0) begin
                    report_mismatch("unexpected result", 32'(rsp), 32'd0);
                end else begin
                    want = verdicts_due.pop_front();
                    if (rsp.blocked !== want.blocked)
                        report_mismatch("blocked", 32'(rsp.blocked), 32'(want.blocked));
                    if (rsp.action !== want.action)
                        report_mismatch("action", 32'(rsp.action), 32'(want.action));
                    if (rsp.slot !== want.slot)
                        report_mismatch("slot", 32'(rsp.slot), 32'(want.slot));
                end
            end
            if (req_valid && req_ready) begin
                judge_request(req, want);
                verdicts_due.push_back(want);
            end
            due_count <= verdicts_due.size();
        end
    end

endmodule

@@ bench/timed_exclusion_table_core_test.sv @@
// stimulus and verdict for the timed exclusion table core
module timed_exclusion_table_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import tet_pkg::*;

    // the random request count, keys of -1 not counted
    localparam int RANDOM_REQUESTS = 650;
    // drain wait after the last result, longer than the worst unstalled item
    localparam int DRAIN_CYCLES    = 40;
    // long receiver hold-off, far longer than one scan so the input side backs up
    localparam int HOLD_CYCLES     = 180;
    // generous ceiling: every request at full scan plus worst gaps and stalls
    localparam int CYCLE_LIMIT     = 200000;

    logic     clk       = 1'b0;
    logic     rst_n;
    logic     req_valid = 1'b0;
    logic     req_ready;
    tet_req_t req       = '0;
    logic     rsp_valid;
    logic     rsp_ready = 1'b0;
    tet_rsp_t rsp;

    int fail_count;
    int pending;
    int cycles = 0;

    // set by the stimulus, read by the receiver
    bit hold_wanted = 0;
    bit calm        = 0;

    always #1 clk = ~clk;

    timed_exclusion_table_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    timed_exclusion_table_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req        (req),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .rsp        (rsp),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // hard stop in case the block hangs or a result never shows up
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic tet_req_t make_req(input logic kind, input logic signed [KEY_W-1:0] key,
                                          input logic [TIME_W-1:0] now,
                                          input logic [DUR_W-1:0] duration);
        tet_req_t r;
        r.kind     = kind;
        r.key      = key;
        r.now      = now;
        r.duration = duration;
        return r;
    endfunction

    // offers one request and holds it until the transfer happens, then maybe idles
    task automatic send(input tet_req_t item);
        int gap;
        req       <= item;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (!req_ready);
        gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
        if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // receiver: random stall bursts, a long hold-off when asked, and none at the end
    initial begin
        while (rst_n !== 1'b1) @(posedge clk);
        forever begin
            if (hold_wanted) begin
                hold_wanted = 0;
                rsp_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end else if (calm || $urandom_range(0, 3) != 0) begin
                rsp_ready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end else begin
                rsp_ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
    end

    initial begin
        logic [TIME_W-1:0]       clock_now;
        logic signed [KEY_W-1:0] key;
        logic                    kind;
        logic [DUR_W-1:0]        duration;
        int                      counted;
        int                      pick;

        // reset edge at time zero so the asynchronous reset takes effect
        rst_n <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty table, the none key, expiry boundary, refresh
        send(make_req(KIND_QUERY, 16'sd5, 32'd100, 16'd0));
        send(make_req(KIND_ADD, -16'sd1, 32'd100, 16'd40));
        send(make_req(KIND_QUERY, -16'sd1, 32'd100, 16'd0));
        send(make_req(KIND_ADD, 16'sd0, 32'd100, 16'd0));
        send(make_req(KIND_QUERY, 16'sd0, 32'd100, 16'd0));
        send(make_req(KIND_ADD, 16'sd32767, 32'd100, 16'hFFFF));
        send(make_req(KIND_QUERY, 16'sd32767, 32'd101, 16'hFFFF));
        send(make_req(KIND_ADD, 16'sd0, 32'd105, 16'd10));
        send(make_req(KIND_QUERY, 16'sd0, 32'd115, 16'd0));

        // fill the table; some entries share an expiry so replacement hits a tie
        for (int k = 1; k <= 14; k++)
            send(make_req(KIND_ADD, KEY_W'(k), 32'd120, DUR_W'((k % 3) * 5)));

        // full table: earliest expiry goes, then the lowest of the tied ones
        send(make_req(KIND_ADD, 16'sd100, 32'd121, 16'd50));
        send(make_req(KIND_ADD, 16'sd101, 32'd121, 16'd50));

        // saturating expiry at the top of the time range, then time going backwards
        send(make_req(KIND_ADD, 16'sd32767, 32'hFFFF_FFF0, 16'hFFFF));
        send(make_req(KIND_QUERY, 16'sd32767, 32'hFFFF_FFFE, 16'd0));
        send(make_req(KIND_QUERY, 16'sd32767, 32'd50, 16'd0));

        // random: mostly a small key pool so refresh and replacement keep happening
        clock_now = 32'd200;
        counted = 0;
        while (counted < RANDOM_REQUESTS) begin
            kind = 1'($urandom_range(0, 1));
            pick = $urandom_range(0, 99);
            if (pick < 80)
                key = KEY_W'($urandom_range(0, 23));
            else if (pick < 93)
                key = KEY_W'($urandom_range(0, 32767));
            else if (pick < 96)
                key = 16'sd32767;
            else
                key = -16'sd1;

            pick = $urandom_range(0, 99);
            if (pick < 85)
                clock_now = clock_now + $urandom_range(0, 30);
            else if (pick < 93)
                clock_now = clock_now + $urandom_range(0, 2000);
            else if (pick < 97)
                clock_now = $urandom();
            else if (clock_now > 50)
                clock_now = clock_now - $urandom_range(0, 50);

            pick = $urandom_range(0, 99);
            if (pick < 70)
                duration = DUR_W'($urandom_range(0, 120));
            else if (pick < 90)
                duration = DUR_W'($urandom_range(0, 3000));
            else
                duration = DUR_W'($urandom_range(0, 65535));

            if (key != -16'sd1)
                counted++;
            if (counted == 60)
                hold_wanted = 1;
            if (counted >= RANDOM_REQUESTS - 100)
                calm = 1;
            send(make_req(kind, key, clock_now, duration));
        end
        req_valid <= 1'b0;

        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
